/* sv/lsact_pkg.sv */
// ----------------------------------------------------------------------------
// lsact_pkg
// Shared types and constants of the set-associative cache tag core.
// ----------------------------------------------------------------------------
package lsact_pkg;

	localparam int MAX_SETS_DEF    = 64;
	localparam int MAX_WAYS_DEF    = 8;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int ADDR_W   = 64;
	localparam int SHAMT_W  = 7;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;
	localparam int FUNC_W   = 2;
	localparam int TOTAL_W  = 32;
	localparam int SETRAW_W = 7;
	localparam int SETRAW_N = 128;

	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS       = 2'd2;

	localparam logic [2:0] SET_BITS_RST   = 3'd4;
	localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
	localparam logic [3:0] WAYS_RST       = 4'd1;

	localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_MISS  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} lsact_state_t;

endpackage

/* sv/lru_set_assoc_cache_tags_core.sv */
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_tags_core: LRU set-associative cache tag core
// Words are taken one at a time: accept and read the set row, compare the
// ways, then rank update and write-back into the set memories, which waits
// for a free output register that holds the result word; no new word is
// taken meanwhile. After reset a clearing pass zeroes valid and rank rows.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_tags_core
	import lsact_pkg::*;
#(
	parameter int MAX_SETS    = MAX_SETS_DEF,
	parameter int MAX_WAYS    = MAX_WAYS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [ADDR_W-1:0]     s_axis_tdata,  // [63:0] address
	input  logic [FUNC_W-1:0]     s_axis_tuser,  // [1:0] func
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [3*TOTAL_W-1:0]  m_axis_tdata,  // [31:0] hits_total, [63:32] misses_total,
	                                             // [95:64] evictions_total
	output logic [2:0]            m_axis_tuser   // [1:0] outcome, [2] extra_hit
);

	localparam int SI_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int RW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CW   = COUNT_WIDTH;

	typedef struct packed {
		logic [MAX_WAYS-1:0]         valid;
		logic [MAX_WAYS-1:0][RW-1:0] rank;
	} vr_row_t;

	typedef logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_row_t;

	// configuration
	logic [2:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			block_bits_q <= BLOCK_BITS_RST;
			ways_q       <= WAYS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SET_BITS:   set_bits_q   <= pwdata[2:0];
				REG_BLOCK_BITS: block_bits_q <= pwdata[5:0];
				REG_WAYS:       ways_q       <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SET_BITS:   prdata = APB_DW'(set_bits_q);
			REG_BLOCK_BITS: prdata = APB_DW'(block_bits_q);
			REG_WAYS:       prdata = APB_DW'(ways_q);
			default:        prdata = '0;
		endcase
	end

	// set index wrap table
	logic [SI_W-1:0] set_lut [SETRAW_N];

	for (genvar g = 0; g < SETRAW_N; g++) begin : g_lut
		assign set_lut[g] = SI_W'(g % MAX_SETS);
	end

	// accept stage: split address
	logic [ADDR_W-1:0]   addr_sh;
	logic [SETRAW_W-1:0] set_raw;
	logic [SI_W-1:0]     in_set;
	logic [SHAMT_W-1:0]  tag_shamt;
	logic [ADDR_W-1:0]   in_tag;
	logic                in_fire;

	always_comb begin
		addr_sh   = s_axis_tdata >> block_bits_q;
		set_raw   = addr_sh[SETRAW_W-1:0] & ~(7'h7f << set_bits_q);
		in_set    = set_lut[set_raw];
		tag_shamt = SHAMT_W'(block_bits_q) + SHAMT_W'(set_bits_q);
		in_tag    = tag_shamt[6] ? '0 : (s_axis_tdata >> tag_shamt[5:0]);
	end

	// state machine
	lsact_state_t state_q, state_d;
	logic [SI_W-1:0] clr_cnt_q;
	logic            vr_we, tag_we, out_load;
	logic            m_valid_q;
	logic            out_free;
	outcome_t        kind_s2;

	assign in_fire  = s_axis_tvalid & s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + SI_W'(1);
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		vr_we         = 1'b0;
		tag_we        = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				vr_we = 1'b1;
				if (clr_cnt_q == SI_W'(MAX_SETS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (out_free) begin
					vr_we    = 1'b1;
					tag_we   = (kind_s2 != OUT_HIT);
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// set memories
	tag_row_t tag_mem [MAX_SETS];
	vr_row_t  vr_mem  [MAX_SETS];

	tag_row_t          tag_rd_s1;
	vr_row_t           vr_rd_s1;
	logic [SI_W-1:0]   set_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic [FUNC_W-1:0] func_s1;

	tag_row_t        tag_wdata;
	vr_row_t         vr_wdata;
	logic [SI_W-1:0] vr_waddr;

	assign vr_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : set_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tag_rd_s1 <= tag_mem[in_set];
			vr_rd_s1  <= vr_mem[in_set];
			set_s1    <= in_set;
			tag_s1    <= in_tag;
			func_s1   <= s_axis_tuser;
		end
		if (tag_we) tag_mem[set_s1] <= tag_wdata;
		if (vr_we)  vr_mem[vr_waddr] <= vr_wdata;
	end

	// lookup
	logic [4:0]          ways_eff;
	logic [MAX_WAYS-1:0] in_use, hit_vec, inv_vec;
	logic [RW-1:0]       hit_way, inv_way, vic_way;
	logic [RW-1:0]       vic_rank;
	outcome_t            kind_d;
	logic [RW-1:0]       way_d;
	logic [RW:0]         limit_d;

	always_comb begin
		if (ways_q == 4'd0)
			ways_eff = 5'd1;
		else if ({1'b0, ways_q} > 5'(MAX_WAYS))
			ways_eff = 5'(MAX_WAYS);
		else
			ways_eff = {1'b0, ways_q};
		hit_way = '0;
		inv_way = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i]  = (5'(i) < ways_eff);
			hit_vec[i] = in_use[i] & vr_rd_s1.valid[i] & (tag_rd_s1[i] == tag_s1);
			inv_vec[i] = in_use[i] & ~vr_rd_s1.valid[i];
		end
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_way = RW'(i);
			if (inv_vec[i]) inv_way = RW'(i);
		end
		vic_way  = '0;
		vic_rank = vr_rd_s1.rank[0];
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (in_use[i] && vr_rd_s1.rank[i] > vic_rank) begin
				vic_way  = RW'(i);
				vic_rank = vr_rd_s1.rank[i];
			end
		end
		if (|hit_vec) begin
			kind_d  = OUT_HIT;
			way_d   = hit_way;
			limit_d = {1'b0, vr_rd_s1.rank[hit_way]};
		end else if (|inv_vec) begin
			kind_d  = OUT_MISS;
			way_d   = inv_way;
			limit_d = (RW + 1)'(MAX_WAYS);
		end else begin
			kind_d  = OUT_EVICT;
			way_d   = vic_way;
			limit_d = {1'b0, vic_rank};
		end
	end

	logic [RW-1:0]       way_s2;
	logic [RW:0]         limit_s2;
	logic [MAX_WAYS-1:0] in_use_s2;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			kind_s2   <= kind_d;
			way_s2    <= way_d;
			limit_s2  <= limit_d;
			in_use_s2 <= in_use;
		end
	end

	// update
	logic [MAX_WAYS-1:0] valid_new;

	always_comb begin
		tag_wdata = tag_rd_s1;
		valid_new = vr_rd_s1.valid;
		vr_wdata  = vr_rd_s1;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (RW'(i) == way_s2) begin
				tag_wdata[i] = tag_s1;
				if (kind_s2 != OUT_HIT) valid_new[i] = 1'b1;
			end
		end
		vr_wdata.valid = valid_new;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (RW'(i) == way_s2)
				vr_wdata.rank[i] = '0;
			else if (in_use_s2[i] && valid_new[i]
			         && {1'b0, vr_rd_s1.rank[i]} < limit_s2
			         && vr_rd_s1.rank[i] < RW'(MAX_WAYS - 1))
				vr_wdata.rank[i] = vr_rd_s1.rank[i] + RW'(1);
		end
		if (state_q == ST_CLEAR) vr_wdata = '0;
	end

	// counters
	logic [CW-1:0] hits_q, misses_q, evicts_q;
	logic [1:0]    hit_inc;
	logic [CW:0]   hit_sum, miss_sum, evict_sum;
	logic          extra;

	assign extra   = (func_s1 == FUNC_MODIFY);
	assign hit_inc = 2'(kind_s2 == OUT_HIT) + 2'(extra);

	always_comb begin
		hit_sum   = {1'b0, hits_q} + (CW + 1)'(hit_inc);
		miss_sum  = {1'b0, misses_q} + (CW + 1)'(kind_s2 != OUT_HIT);
		evict_sum = {1'b0, evicts_q} + (CW + 1)'(kind_s2 == OUT_EVICT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			misses_q  <= '0;
			evicts_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				hits_q    <= hit_sum[CW]   ? '1 : hit_sum[CW-1:0];
				misses_q  <= miss_sum[CW]  ? '1 : miss_sum[CW-1:0];
				evicts_q  <= evict_sum[CW] ? '1 : evict_sum[CW-1:0];
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result word
	outcome_t outcome_q;
	logic     extra_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			outcome_q <= kind_s2;
			extra_q   <= extra;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = {extra_q, outcome_q};
	assign m_axis_tdata  = {TOTAL_W'(evicts_q), TOTAL_W'(misses_q), TOTAL_W'(hits_q)};

endmodule
